// ===== design/asd_pkg.sv =====
// Shared constants and types for the ADC sample stream deframer.
package asd_pkg;

   localparam int CHANNELS      = 8;
   localparam int MAX_BLOCK_LEN = 1024;

   localparam int CHAN_W    = $clog2(CHANNELS);
   localparam int VALUE_W   = 16;
   localparam int SLOT_W    = 10;
   localparam int LEN_W     = 11;
   localparam int OVR_W     = 16;
   localparam int BYTE_W    = 8;

   localparam int HEADER_BIT  = 7;
   localparam int OVERRUN_BIT = 6;

   localparam logic [LEN_W-1:0]   BLOCK_LEN_RESET = LEN_W'(400);
   localparam logic [LEN_W-1:0]   BLOCK_LEN_MAX   = LEN_W'(MAX_BLOCK_LEN);
   localparam logic [OVR_W-1:0]   OVR_SAT         = {OVR_W{1'b1}};

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [VALUE_W-1:0]  value;
      logic [SLOT_W-1:0]   slot;
      logic                done;
      logic [CHANNELS-1:0] mask;
      logic [OVR_W-1:0]    overrun;
   } sample_type;

endpackage

// ===== design/asd_decode.sv =====
// Byte decoder holding the deframer state and forming one sample per data word.
module asd_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [asd_pkg::BYTE_W-1:0] stream_byte,
   input  logic [asd_pkg::LEN_W-1:0]  block_length,
   output asd_pkg::sample_type        sample
);
   import asd_pkg::*;

   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [CHAN_W-1:0]   cur_ch_ff, cur_ch_in;
   logic [CHAN_W-1:0]   prev_ch_ff, prev_ch_in;
   logic                prev_valid_ff, prev_valid_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CHANNELS-1:0] mask_ff, mask_in;
   logic [OVR_W-1:0]    ovr_ff, ovr_in;

   logic                is_header;
   logic [VALUE_W-1:0]  acc_sum;
   logic                advance;
   logic [LEN_W-1:0]    slot_inc;
   logic [LEN_W-1:0]    eff_len;
   logic                wrap;
   logic [SLOT_W-1:0]   slot_next;
   logic [CHANNELS-1:0] mask_next;

   always_comb begin
      is_header = stream_byte[HEADER_BIT];
      acc_sum   = acc_ff + VALUE_W'(stream_byte[6:0]);
      advance   = prev_valid_ff && (cur_ch_ff < prev_ch_ff);
      slot_inc  = LEN_W'(slot_ff) + LEN_W'(1);
      if (block_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (block_length > BLOCK_LEN_MAX) begin
         eff_len = BLOCK_LEN_MAX;
      end else begin
         eff_len = block_length;
      end
      wrap = advance && (slot_inc >= eff_len);
      if (wrap) begin
         slot_next = '0;
      end else if (advance) begin
         slot_next = slot_inc[SLOT_W-1:0];
      end else begin
         slot_next = slot_ff;
      end
      mask_next = (wrap ? '0 : mask_ff) | (CHANNELS'(1) << cur_ch_ff);

      sample.channel = cur_ch_ff;
      sample.value   = acc_sum;
      sample.slot    = slot_next;
      sample.done    = wrap;
      sample.mask    = wrap ? mask_ff : '0;
      sample.overrun = ovr_ff;
   end

   always_comb begin
      acc_in        = acc_ff;
      cur_ch_in     = cur_ch_ff;
      prev_ch_in    = prev_ch_ff;
      prev_valid_in = prev_valid_ff;
      slot_in       = slot_ff;
      mask_in       = mask_ff;
      ovr_in        = ovr_ff;
      if (step) begin
         if (is_header) begin
            if (stream_byte[OVERRUN_BIT] && (ovr_ff != OVR_SAT)) begin
               ovr_in = ovr_ff + OVR_W'(1);
            end
            cur_ch_in = stream_byte[5:3];
            acc_in    = VALUE_W'({stream_byte[2:0], 7'b0});
         end else begin
            acc_in        = acc_sum;
            slot_in       = slot_next;
            mask_in       = mask_next;
            prev_ch_in    = cur_ch_ff;
            prev_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         cur_ch_ff     <= '0;
         prev_ch_ff    <= '0;
         prev_valid_ff <= 1'b0;
         slot_ff       <= '0;
         mask_ff       <= '0;
         ovr_ff        <= '0;
      end else begin
         acc_ff        <= acc_in;
         cur_ch_ff     <= cur_ch_in;
         prev_ch_ff    <= prev_ch_in;
         prev_valid_ff <= prev_valid_in;
         slot_ff       <= slot_in;
         mask_ff       <= mask_in;
         ovr_ff        <= ovr_in;
      end
   end

endmodule

// ===== design/asd_out_reg.sv =====
// Result register that holds one sample until the receiver takes it.
module asd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  asd_pkg::sample_type in_sample,
   output logic                in_free,
   output logic                out_valid,
   output asd_pkg::sample_type out_sample,
   input  logic                out_stall
);
   import asd_pkg::*;

   logic       valid_ff, valid_in;
   sample_type sample_ff;

   always_comb begin
      in_free  = !valid_ff || !out_stall;
      valid_in = in_free ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && in_valid) begin
         sample_ff <= in_sample;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

// ===== design/adc_sample_stream_deframer.sv =====
// Top level of the ADC sample stream deframer.
// A data word is captured in the input register, decoded, and its sample is registered in the result register.
// Throughput: one word per cycle while the result register is free; a header word never waits and gives no sample.
// The pace is set by the input register feeding the decoder and the result register.
// Synchronous active-high reset clears the valid flags and decoder state; block length returns to 400.
module adc_sample_stream_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [asd_pkg::BYTE_W-1:0]         req_stream_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [asd_pkg::CHAN_W-1:0]         rsp_sample_channel,
   output logic [asd_pkg::VALUE_W-1:0]        rsp_sample_value,
   output logic [asd_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic                               rsp_block_done,
   output logic [asd_pkg::CHANNELS-1:0]       rsp_finished_channel_mask,
   output logic [asd_pkg::OVR_W-1:0]          rsp_overrun_count,
   input  logic                               csr_write_enable,
   input  logic [asd_pkg::LEN_W-1:0]          csr_write_data
);
   import asd_pkg::*;

   logic [LEN_W-1:0]  blen_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_go;
   logic              out_free;
   sample_type        dec_sample;
   sample_type        rsp_sample;

   always_comb begin
      s1_go       = s1_valid_ff && (s1_byte_ff[HEADER_BIT] || out_free);
      req_stall   = s1_valid_ff && !s1_go;
      s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         blen_ff     <= BLOCK_LEN_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_write_enable) begin
            blen_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_stream_byte;
      end
   end

   asd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .stream_byte  (s1_byte_ff),
      .block_length (blen_ff),
      .sample       (dec_sample)
   );

   asd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_go && !s1_byte_ff[HEADER_BIT]),
      .in_sample  (dec_sample),
      .in_free    (out_free),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample),
      .out_stall  (rsp_stall)
   );

   assign rsp_sample_channel        = rsp_sample.channel;
   assign rsp_sample_value          = rsp_sample.value;
   assign rsp_slot_index            = rsp_sample.slot;
   assign rsp_block_done            = rsp_sample.done;
   assign rsp_finished_channel_mask = rsp_sample.mask;
   assign rsp_overrun_count         = rsp_sample.overrun;

endmodule
